FILE: src/lrfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrfd_pkg
// Shared constants and types for the range-scan reply deframer.
// ----------------------------------------------------------------------------
package lrfd_pkg;

  localparam int HEADER_BYTES = 26;
  localparam int BLOCK_CHARS  = 64;

  localparam int BYTE_W   = 8;
  localparam int STEP_W   = 12;
  localparam int CLUST_W  = 7;
  localparam int CPV_W    = 2;
  localparam int SPAN_W   = STEP_W + 1;  // end - start + 1 reaches 4096
  localparam int CHARS_W  = 14;
  localparam int VALUE_W  = 18;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_CNT_W  = $clog2(SPAN_W + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CPV   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLUST = 2'd3;

  localparam logic [CPV_W-1:0]   CPV_RESET   = 2'd3;
  localparam logic [STEP_W-1:0]  START_RESET = 12'd0;
  localparam logic [STEP_W-1:0]  END_RESET   = 12'd768;
  localparam logic [CLUST_W-1:0] CLUST_RESET = 7'd1;

  // result kinds
  localparam logic [KIND_W-1:0] K_VALUE   = 2'd0;
  localparam logic [KIND_W-1:0] K_SUM_OK  = 2'd1;
  localparam logic [KIND_W-1:0] K_SUM_BAD = 2'd2;
  localparam logic [KIND_W-1:0] K_DONE    = 2'd3;

  localparam logic [BYTE_W-1:0] CHAR_BASE = 8'h30;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

endpackage : lrfd_pkg
`default_nettype wire

FILE: src/lrfd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrfd_div
// Restoring divider, one quotient bit per cycle, for the step-span count.
// ----------------------------------------------------------------------------
module lrfd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lrfd_pkg::SPAN_W-1:0] dividend,
  input  wire logic [lrfd_pkg::CLUST_W-1:0] divisor,
  output logic                             busy,
  output logic [lrfd_pkg::SPAN_W-1:0]      quotient
);

  logic [lrfd_pkg::CLUST_W-1:0]   rem;
  logic [lrfd_pkg::CLUST_W-1:0]   dsr;
  logic [lrfd_pkg::DIV_CNT_W-1:0] cnt;
  logic [lrfd_pkg::CLUST_W:0]     shifted;
  logic [lrfd_pkg::CLUST_W:0]     trial;
  logic                           qbit;

  always_comb begin
    shifted = {rem, quotient[lrfd_pkg::SPAN_W-1]};
    trial   = shifted - {1'b0, dsr};
    qbit    = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= lrfd_pkg::DIV_CNT_W'(lrfd_pkg::SPAN_W);
    end else if (busy) begin
      cnt <= cnt - lrfd_pkg::DIV_CNT_W'(1);
      if (cnt == lrfd_pkg::DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  // remainder stays below the divisor, so it fits the divisor width
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= qbit ? trial[lrfd_pkg::CLUST_W-1:0] : shifted[lrfd_pkg::CLUST_W-1:0];
      quotient <= {quotient[lrfd_pkg::SPAN_W-2:0], qbit};
    end
  end

endmodule : lrfd_div
`default_nettype wire

FILE: src/lrfd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrfd_core
// Frame sequencer: header skip, block framing, sum check and value decode.
// ----------------------------------------------------------------------------
module lrfd_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic [lrfd_pkg::BYTE_W-1:0] in_byte,
  input  wire logic [lrfd_pkg::CPV_W-1:0]  chars_per_value,
  input  wire logic [lrfd_pkg::SPAN_W-1:0] quotient,
  output lrfd_pkg::res_t                   res
);

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_DATA     = 3'd1;
  localparam logic [2:0] PH_SUM      = 3'd2;
  localparam logic [2:0] PH_BLOCK_LF = 3'd3;
  localparam logic [2:0] PH_END_LF1  = 3'd4;
  localparam logic [2:0] PH_END_LF2  = 3'd5;

  logic [2:0]                       phase, phase_next;
  logic [4:0]                       header_count, header_count_next;
  logic [6:0]                       block_char_count, block_char_count_next;
  logic [lrfd_pkg::CHARS_W-1:0]     chars_left, chars_left_next;
  logic [5:0]                       running_sum, running_sum_next;
  logic [lrfd_pkg::VALUE_W-1:0]     value_accum, value_accum_next;
  logic [1:0]                       char_in_value, char_in_value_next;

  logic                             two_wide;
  logic [lrfd_pkg::CHARS_W-1:0]     frame_chars;
  logic [lrfd_pkg::BYTE_W-1:0]      digit8;
  logic [lrfd_pkg::VALUE_W-1:0]     accum_shift;
  logic [7:0]                       sum_expect;

  always_comb begin
    two_wide = (chars_per_value == 2'd2);
    if (two_wide)
      frame_chars = {quotient, 1'b0};
    else
      frame_chars = {1'b0, quotient} + {quotient, 1'b0};
    digit8      = in_byte - lrfd_pkg::CHAR_BASE;
    accum_shift = {value_accum[lrfd_pkg::VALUE_W-7:0], digit8[5:0]};
    sum_expect  = {2'b00, running_sum} + lrfd_pkg::CHAR_BASE;
  end

  always_comb begin
    phase_next            = phase;
    header_count_next     = header_count;
    block_char_count_next = block_char_count;
    chars_left_next       = chars_left;
    running_sum_next      = running_sum;
    value_accum_next      = value_accum;
    char_in_value_next    = char_in_value;
    res                   = '0;

    unique case (phase)
      PH_HEADER: begin
        if (header_count == 5'd0) begin
          chars_left_next       = frame_chars;
          block_char_count_next = '0;
          running_sum_next      = '0;
          value_accum_next      = '0;
          char_in_value_next    = '0;
        end
        if ({1'b0, header_count} + 6'd1 >= 6'(lrfd_pkg::HEADER_BYTES)) begin
          header_count_next = '0;
          phase_next = (chars_left_next == '0) ? PH_END_LF2 : PH_DATA;
        end else begin
          header_count_next = header_count + 5'd1;
        end
      end
      PH_DATA: begin
        running_sum_next      = running_sum + in_byte[5:0];
        block_char_count_next = block_char_count + 7'd1;
        chars_left_next       = chars_left - lrfd_pkg::CHARS_W'(1);
        // last char of a group when index reaches width - 1
        if ((two_wide && char_in_value >= 2'd1) || char_in_value >= 2'd2) begin
          res.valid          = 1'b1;
          res.kind           = lrfd_pkg::K_VALUE;
          res.value          = accum_shift;
          value_accum_next   = '0;
          char_in_value_next = '0;
        end else begin
          value_accum_next   = accum_shift;
          char_in_value_next = char_in_value + 2'd1;
        end
        if (block_char_count_next >= 7'(lrfd_pkg::BLOCK_CHARS) || chars_left_next == '0)
          phase_next = PH_SUM;
      end
      PH_SUM: begin
        res.valid             = 1'b1;
        res.kind              = (in_byte == sum_expect) ? lrfd_pkg::K_SUM_OK
                                                        : lrfd_pkg::K_SUM_BAD;
        running_sum_next      = '0;
        block_char_count_next = '0;
        phase_next = (chars_left == '0) ? PH_END_LF1 : PH_BLOCK_LF;
      end
      PH_BLOCK_LF: phase_next = PH_DATA;
      PH_END_LF1:  phase_next = PH_END_LF2;
      default: begin
        res.valid         = 1'b1;
        res.kind          = lrfd_pkg::K_DONE;
        res.last          = 1'b1;
        phase_next        = PH_HEADER;
        header_count_next = '0;
      end
    endcase

    if (!fire) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_count     <= '0;
      block_char_count <= '0;
      chars_left       <= '0;
      running_sum      <= '0;
      value_accum      <= '0;
      char_in_value    <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      block_char_count <= block_char_count_next;
      chars_left       <= chars_left_next;
      running_sum      <= running_sum_next;
      value_accum      <= value_accum_next;
      char_in_value    <= char_in_value_next;
    end
  end

endmodule : lrfd_core
`default_nettype wire

FILE: src/lidar_range_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_range_frame_deframer
// Deframes range-scan reply bytes into decoded values and block sum results.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_byte
//   out      out  out_valid / out_ready  kind, value, last
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; a result is registered in the cycle
// after its byte is accepted. The frame character count needs a step-span divide
// by cluster_count; a serial divider runs it after reset and after every register
// write, and in_ready is low while it runs. cfg_ready is always high.
// A result held by out_ready low stalls input until it is taken.
// ----------------------------------------------------------------------------
module lidar_range_frame_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lrfd_pkg::BYTE_W-1:0]     in_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lrfd_pkg::KIND_W-1:0]          kind,
  output logic [lrfd_pkg::VALUE_W-1:0]         value,
  output logic                                 last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lrfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lrfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [lrfd_pkg::CPV_W-1:0]   chars_per_value;
  logic [lrfd_pkg::STEP_W-1:0]  start_step;
  logic [lrfd_pkg::STEP_W-1:0]  end_step;
  logic [lrfd_pkg::CLUST_W-1:0] cluster_count;

  logic                          div_req;
  logic                          div_busy;
  logic [lrfd_pkg::SPAN_W-1:0]   quotient;
  logic [lrfd_pkg::SPAN_W-1:0]   span;
  logic [lrfd_pkg::CLUST_W-1:0]  divisor;
  logic                          fire;
  lrfd_pkg::res_t                res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_per_value <= lrfd_pkg::CPV_RESET;
      start_step      <= lrfd_pkg::START_RESET;
      end_step        <= lrfd_pkg::END_RESET;
      cluster_count   <= lrfd_pkg::CLUST_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrfd_pkg::REG_CPV:   chars_per_value <= cfg_data[lrfd_pkg::CPV_W-1:0];
        lrfd_pkg::REG_START: start_step      <= cfg_data[lrfd_pkg::STEP_W-1:0];
        lrfd_pkg::REG_END:   end_step        <= cfg_data[lrfd_pkg::STEP_W-1:0];
        lrfd_pkg::REG_CLUST: cluster_count   <= cfg_data[lrfd_pkg::CLUST_W-1:0];
        default: ;
      endcase
    end
  end

  // kick the divider the cycle after any write, and once after reset
  always_ff @(posedge clk) begin
    if (rst) div_req <= 1'b1;
    else     div_req <= cfg_valid;
  end

  always_comb begin
    if (end_step < start_step)
      span = '0;
    else
      span = {1'b0, end_step} - {1'b0, start_step} + lrfd_pkg::SPAN_W'(1);
    divisor = (cluster_count == '0) ? lrfd_pkg::CLUST_W'(1) : cluster_count;
  end

  lrfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_req),
    .dividend (span),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign in_ready = !div_req && !div_busy && (!out_valid || out_ready);
  assign fire     = in_valid && in_ready;

  lrfd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .in_byte         (in_byte),
    .chars_per_value (chars_per_value),
    .quotient        (quotient),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind  <= res.kind;
      value <= res.value;
      last  <= res.last;
    end
  end

endmodule : lidar_range_frame_deframer
`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the range-scan reply deframer. Whole reply frames
// are built from the register settings: random header, data characters cut
// into blocks, sum bytes (some corrupted) and line feeds. A predictor tracks
// the deframer state per accepted byte; every result beat is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import lrfd_pkg::*;

  localparam int RANDOM_BYTES = 1080;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_CHARS    = 260;

  typedef enum logic [2:0] {
    PH_HEADER, PH_DATA, PH_SUM, PH_BLOCK_LF, PH_END_LF1, PH_END_LF2
  } rx_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } scan_result_t;

  typedef struct packed {
    logic [CPV_W-1:0]   cpv;
    logic [STEP_W-1:0]  first;
    logic [STEP_W-1:0]  stop;
    logic [CLUST_W-1:0] clust;
    logic               rnd_fill;
    logic [BYTE_W-1:0]  fill;
    logic               bad_sum;
    logic [1:0]         n_typed;
    scan_result_t [2:0] typed;
  } frame_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [VALUE_W-1:0] value;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lidar_range_frame_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .value(value), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // register mirror
  logic [CPV_W-1:0]   cfg_cpv   = CPV_RESET;
  logic [STEP_W-1:0]  cfg_start = START_RESET;
  logic [STEP_W-1:0]  cfg_end   = END_RESET;
  logic [CLUST_W-1:0] cfg_clust = CLUST_RESET;

  // deframer state as predicted
  rx_phase_t         ph         = PH_HEADER;
  logic [4:0]        hdr_cnt    = '0;
  logic [6:0]        blk_cnt    = '0;
  logic [CHARS_W-1:0] chars_left = '0;
  logic [5:0]        run_sum    = '0;
  logic [VALUE_W-1:0] acc       = '0;
  logic [1:0]        grp_pos    = '0;

  scan_result_t results_due[$];
  frame_case_t  frame_cases[$];

  bit hand_expected = 1'b0;  // current frame's results are typed in the table
  bit calm = 1'b0;           // no idling on either side
  int errors = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int cfg_writes = 0;
  int bad_sums = 0;
  int quiet_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic scan_result_t res(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
                                       logic l);
    scan_result_t r;
    r.kind = k;
    r.value = v;
    r.last = l;
    return r;
  endfunction

  function automatic frame_case_t frame_case(logic [CPV_W-1:0] cpv,
      logic [STEP_W-1:0] first, logic [STEP_W-1:0] stop, logic [CLUST_W-1:0] clust,
      logic rnd_fill, logic [BYTE_W-1:0] fill, logic bad_sum, logic [1:0] n_typed,
      scan_result_t t0, scan_result_t t1, scan_result_t t2);
    frame_case_t f;
    f.cpv = cpv;
    f.first = first;
    f.stop = stop;
    f.clust = clust;
    f.rnd_fill = rnd_fill;
    f.fill = fill;
    f.bad_sum = bad_sum;
    f.n_typed = n_typed;
    f.typed[0] = t0;
    f.typed[1] = t1;
    f.typed[2] = t2;
    return f;
  endfunction

  // data characters in a frame for a given register setting
  function automatic int chars_for(logic [CPV_W-1:0] cpv, logic [STEP_W-1:0] first,
                                   logic [STEP_W-1:0] stop, logic [CLUST_W-1:0] clust);
    int span;
    int div;
    if (stop < first) return 0;
    span = int'(stop) - int'(first) + 1;
    div = (clust == 0) ? 1 : int'(clust);
    return (span / div) * ((cpv == 2'd2) ? 2 : 3);
  endfunction

  function automatic void note_result(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
                                      logic l);
    if (!hand_expected) results_due.push_back(res(k, v, l));
  endfunction

  function automatic void deframe_byte(logic [BYTE_W-1:0] b);
    case (ph)
      PH_HEADER: begin
        if (hdr_cnt == 0) begin
          chars_left = CHARS_W'(chars_for(cfg_cpv, cfg_start, cfg_end, cfg_clust));
          blk_cnt = '0;
          run_sum = '0;
          acc = '0;
          grp_pos = '0;
        end
        if (int'(hdr_cnt) + 1 >= HEADER_BYTES) begin
          hdr_cnt = '0;
          ph = (chars_left == 0) ? PH_END_LF2 : PH_DATA;
        end else begin
          hdr_cnt = hdr_cnt + 5'd1;
        end
      end
      PH_DATA: begin
        run_sum = run_sum + b[5:0];
        blk_cnt = blk_cnt + 7'd1;
        chars_left = chars_left - CHARS_W'(1);
        acc = {acc[VALUE_W-7:0], 6'(b - CHAR_BASE)};
        if (int'(grp_pos) + 1 >= ((cfg_cpv == 2'd2) ? 2 : 3)) begin
          note_result(K_VALUE, acc, 1'b0);
          acc = '0;
          grp_pos = '0;
        end else begin
          grp_pos = grp_pos + 2'd1;
        end
        if (int'(blk_cnt) >= BLOCK_CHARS || chars_left == 0) ph = PH_SUM;
      end
      PH_SUM: begin
        note_result((b == {2'b00, run_sum} + CHAR_BASE) ? K_SUM_OK : K_SUM_BAD, '0, 1'b0);
        run_sum = '0;
        blk_cnt = '0;
        ph = (chars_left == 0) ? PH_END_LF1 : PH_BLOCK_LF;
      end
      PH_BLOCK_LF: ph = PH_DATA;
      PH_END_LF1:  ph = PH_END_LF2;
      default: begin
        note_result(K_DONE, '0, 1'b1);
        ph = PH_HEADER;
        hdr_cnt = '0;
      end
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CPV:   cfg_cpv = data[CPV_W-1:0];
      REG_START: cfg_start = data[STEP_W-1:0];
      REG_END:   cfg_end = data[STEP_W-1:0];
      REG_CLUST: cfg_clust = data[CLUST_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // header bytes give no result; wait for every due result, then idle with in_valid low
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] lf_byte();
    return ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom) : 8'h0A;
  endfunction

  task automatic send_frame(input logic rnd_fill, input logic [BYTE_W-1:0] fill,
                            input int bad_pct);
    int n;
    int in_blk;
    logic [5:0] s;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] sum_byte;
    n = chars_for(cfg_cpv, cfg_start, cfg_end, cfg_clust);
    repeat (HEADER_BYTES) push_byte(BYTE_W'($urandom));
    in_blk = 0;
    s = '0;
    for (int i = 0; i < n; i++) begin
      if (!rnd_fill) c = fill;
      else if ($urandom_range(0, 4) == 0) c = BYTE_W'($urandom);
      else c = BYTE_W'($urandom_range(8'h30, 8'h6F));
      push_byte(c);
      s = s + c[5:0];
      in_blk++;
      if (in_blk == BLOCK_CHARS || i == n - 1) begin
        sum_byte = {2'b00, s} + CHAR_BASE;
        if ($urandom_range(0, 99) < bad_pct) begin
          sum_byte = sum_byte ^ BYTE_W'($urandom_range(1, 255));
          bad_sums++;
        end
        push_byte(sum_byte);
        push_byte(lf_byte());
        in_blk = 0;
        s = '0;
      end
    end
    // closing line feed; with no data it is the only byte after the header
    push_byte(lf_byte());
    frames_sent++;
  endtask

  task automatic rand_config();
    logic [CFG_DATA_W-1:0] d_cpv;
    logic [STEP_W-1:0] s;
    logic [STEP_W-1:0] e;
    logic [CLUST_W-1:0] c;
    int pick;
    d_cpv = CFG_DATA_W'($urandom);
    s = ($urandom_range(0, 1) == 0) ? STEP_W'($urandom) : cfg_start;
    pick = $urandom_range(0, 9);
    if (pick == 0) e = STEP_W'($urandom);
    else if (pick == 1) e = (s > 12'd4000) ? 12'd4095 : s + 12'($urandom_range(20, 90));
    else e = (s > 12'd4070) ? 12'd4095 : s + 12'($urandom_range(0, 25));
    pick = $urandom_range(0, 9);
    if (pick == 0) c = '0;
    else if (pick == 1) c = 7'd127;
    else if (pick == 2) c = CLUST_W'($urandom);
    else c = CLUST_W'($urandom_range(1, 4));
    if (chars_for(d_cpv[CPV_W-1:0], s, e, c) > MAX_CHARS)
      e = (s > 12'd4080) ? 12'd4095 : s + 12'($urandom_range(0, 12));
    write_reg(REG_CPV, d_cpv);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_CLUST, {5'($urandom), c});
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, none while calm
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        if (errors < 10)
          $display("unexpected result beat: kind %0d value %0h last %0d", kind, value, last);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (kind !== want.kind || value !== want.value || last !== want.last) begin
          if (errors < 10)
            $display("result %0d mismatch: kind %0d/%0d value %0h/%0h last %0d/%0d (exp/act)",
                     results_seen, want.kind, kind, want.value, value, want.last, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding",
               quiet_cycles, results_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int rnd_start;
    frame_cases.push_back(frame_case(2'd3, 12'd5, 12'd4, 7'd1, 1'b1, 8'h00, 1'b0, 2'd1,
                                     res(K_DONE, '0, 1'b1), '0, '0));  // reversed span
    frame_cases.push_back(frame_case(2'd2, 12'd0, 12'd9, 7'd99, 1'b1, 8'h00, 1'b0, 2'd1,
                                     res(K_DONE, '0, 1'b1), '0, '0));  // cluster > span
    frame_cases.push_back(frame_case(2'd2, 12'd7, 12'd7, 7'd1, 1'b0, 8'h6F, 1'b0, 2'd3,
        res(K_VALUE, 18'hFFF, 1'b0), res(K_SUM_OK, '0, 1'b0), res(K_DONE, '0, 1'b1)));
    frame_cases.push_back(frame_case(2'd1, 12'd4095, 12'd4095, 7'd1, 1'b0, 8'h6F, 1'b0,
        2'd3, res(K_VALUE, 18'h3FFFF, 1'b0), res(K_SUM_OK, '0, 1'b0),
        res(K_DONE, '0, 1'b1)));
    frame_cases.push_back(frame_case(2'd2, 12'd0, 12'd0, 7'd1, 1'b0, 8'h30, 1'b1, 2'd3,
        res(K_VALUE, 18'h0, 1'b0), res(K_SUM_BAD, '0, 1'b0), res(K_DONE, '0, 1'b1)));
    frame_cases.push_back(frame_case(2'd0, 12'd0, 12'd1, 7'd0, 1'b1, 8'h00, 1'b0, 2'd0,
                                     '0, '0, '0));  // cluster zero acts as one
    frame_cases.push_back(frame_case(2'd3, 12'd0, 12'd4095, 7'd127, 1'b1, 8'h00, 1'b0, 2'd0,
                                     '0, '0, '0));  // groups straddle the block edge
    frame_cases.push_back(frame_case(2'd2, 12'd0, 12'd4095, 7'd99, 1'b0, 8'h00, 1'b0, 2'd0,
                                     '0, '0, '0));  // chars below the base
    frame_cases.push_back(frame_case(2'd3, 12'd100, 12'd120, 7'd1, 1'b0, 8'hFF, 1'b0, 2'd0,
                                     '0, '0, '0));
    frame_cases.push_back(frame_case(2'd2, 12'd10, 12'd41, 7'd1, 1'b1, 8'h00, 1'b0, 2'd0,
                                     '0, '0, '0));  // exactly one full block
    frame_cases.push_back(frame_case(2'd2, 12'd0, 12'd63, 7'd1, 1'b1, 8'h00, 1'b1, 2'd0,
                                     '0, '0, '0));  // two full blocks, bad sums

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (frame_cases[i]) begin
      settle();
      write_reg(REG_CPV, CFG_DATA_W'(frame_cases[i].cpv));
      write_reg(REG_START, frame_cases[i].first);
      write_reg(REG_END, frame_cases[i].stop);
      write_reg(REG_CLUST, CFG_DATA_W'(frame_cases[i].clust));
      cfg_valid <= 1'b0;
      calm = (i % 3 == 0);
      hand_expected = (frame_cases[i].n_typed != 0);
      for (int j = 0; j < int'(frame_cases[i].n_typed); j++)
        results_due.push_back(frame_cases[i].typed[j]);
      send_frame(frame_cases[i].rnd_fill, frame_cases[i].fill,
                 frame_cases[i].bad_sum ? 100 : 0);
      hand_expected = 1'b0;
    end

    rnd_start = bytes_sent;
    while (bytes_sent - rnd_start < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 55) begin
        settle();
        rand_config();
      end
      calm = ($urandom_range(0, 3) == 0);
      send_frame(1'b1, 8'h00, 15);
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d frames, %0d bytes, %0d register writes", frames_sent, bytes_sent,
             cfg_writes);
    $display("%0d result beats checked, %0d corrupted sums, %0d errors", results_seen,
             bad_sums, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/lrfd_pkg.sv
src/lrfd_div.sv
src/lrfd_core.sv
src/lidar_range_frame_deframer.sv
dv/testbench.sv
